/* src/rpwc_pkg.sv */
// Package for the radix partition write combiner.
// Holds word types, table entry layout, register indexes and fixed constants.
// No dependencies.
package rpwc_pkg;

	// Keys per cache line, and the key slots a partition buffers before the line goes out
	localparam int LINE_ENTRIES = 4;
	localparam int BUF_SLOTS    = LINE_ENTRIES - 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 18;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_BITS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES_PER_BLOCK = 2'd1;

	// Input commands
	localparam logic CMD_KEY   = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key;
		logic [11:0] flush_partition;
	} item_word_t;

	typedef struct packed {
		logic [11:0] partition;
		logic [31:0] block_index;
		logic [16:0] offset_in_block;
		logic [2:0]  entry_count;
		logic [63:0] key_first;
		logic [63:0] key_second;
		logic [63:0] key_third;
		logic [63:0] key_fourth;
		logic        block_full;
		logic [39:0] partition_total;
	} line_word_t;

	typedef struct packed {
		logic [3:0]  partition_bits;
		logic [17:0] entries_per_block;
	} cfg_t;

	// Classified word between front and back
	typedef struct packed {
		logic        cmd;
		logic [11:0] part;
		logic [63:0] key;
	} qitem_t;

	// Per-partition table entry
	typedef struct packed {
		logic [1:0]  fill;
		logic [17:0] target;
		logic [23:0] filled;
	} part_state_t;

	// Write record before the index and total arithmetic
	typedef struct packed {
		logic [11:0]                  part;
		logic [23:0]                  filled;
		logic [17:0]                  target;
		logic [2:0]                   count;
		logic [LINE_ENTRIES-1:0][63:0] keys;
		logic                         full;
	} rec_t;

endpackage

/* src/rpwc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rpwc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/rpwc_front.sv */
// Front end: accepts words, extracts the bucket and reduces it modulo PARTITIONS.
// Depends on rpwc_pkg.
module rpwc_front import rpwc_pkg::*; #(
	parameter int PARTITIONS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       hold,
	input  logic       item_valid,
	input  item_word_t item,
	output logic       item_stall,
	output logic       push,
	output qitem_t     push_item,
	input  logic       q_full
);

	localparam int RECIP = 65536 / PARTITIONS;

	logic        valid_s1, valid_s2;
	logic        cmd_s1, cmd_s2;
	logic [63:0] key_s1, key_s2;
	logic [14:0] raw_s1, raw_s2;
	logic [14:0] quo_s1;
	logic [11:0] part_s2;
	logic        adv_s1, adv_s2, accept;
	logic [14:0] top_bits, raw;
	logic [3:0]  shamt;
	logic [30:0] prod;
	logic [27:0] back_prod;
	logic [15:0] rem, rem_fix;

	assign adv_s2     = valid_s2 && !q_full;
	assign adv_s1     = valid_s1 && (!valid_s2 || adv_s2);
	assign item_stall = hold || (valid_s1 && !adv_s1);
	assign accept     = item_valid && !item_stall;

	// Pick the raw bucket: top bits of the key, or the flush partition
	always_comb begin
		top_bits = item.key[63:49];
		shamt    = 4'(15 - int'(cfg.partition_bits));
		if (item.cmd == CMD_FLUSH) begin
			raw = {3'b000, item.flush_partition};
		end else if (cfg.partition_bits == 4'd0) begin
			raw = '0;
		end else begin
			raw = top_bits >> shamt;
		end
		prod = 31'(raw) * 31'(RECIP);
	end

	// Estimate the quotient, low by at most one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= item.cmd;
			key_s1 <= item.key;
			raw_s1 <= raw;
			quo_s1 <= prod[30:16];
		end
	end

	// Remainder with one correction step
	always_comb begin
		back_prod = 28'(quo_s1) * 28'(PARTITIONS);
		rem       = 16'({1'b0, raw_s1}) - back_prod[15:0];
		rem_fix   = (rem >= 16'(PARTITIONS)) ? rem - 16'(PARTITIONS) : rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s2  <= cmd_s1;
			key_s2  <= key_s1;
			raw_s2  <= raw_s1;
			part_s2 <= rem_fix[11:0];
		end
	end

	assign push           = adv_s2;
	assign push_item.cmd  = cmd_s2;
	assign push_item.part = part_s2;
	assign push_item.key  = key_s2;

	a_part_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (32'(part_s2) < 32'(PARTITIONS))) else $error("partition out of range");
	a_part_not_above_raw: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (15'(part_s2) <= raw_s2)) else $error("remainder above bucket");
	a_hold_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !accept) else $error("word taken during clear");

endmodule

/* src/rpwc_queue.sv */
// Short queue between the classifying front end and the table back end.
// Depends on rpwc_pkg.
module rpwc_queue import rpwc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	output logic   full,
	output logic   valid,
	output qitem_t head,
	input  logic   pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	qitem_t        slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid)) else $error("queue underflow");
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(wr_ptr_q - rd_ptr_q) == count_q[PW-1:0]) else $error("queue count mismatch");

endmodule

/* src/rpwc_back.sv */
// Back end: per-partition tables, line combining, block chaining and result register.
// Depends on rpwc_pkg and rpwc_ram.
module rpwc_back import rpwc_pkg::*; #(
	parameter int PARTITIONS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  qitem_t     q_item,
	output logic       q_pop,
	output logic       clearing,
	output logic       line_valid,
	input  logic       line_stall,
	output line_word_t line
);

	localparam int PW  = $clog2(PARTITIONS);
	localparam int STW = $bits(part_state_t);
	localparam logic [1:0] LAST_SLOT = 2'(BUF_SLOTS);

	// Clear sweep
	logic          clr_q;
	logic [PW-1:0] clr_idx_q;

	// Pipeline
	logic       valid_s1, valid_s2, line_valid_q;
	qitem_t     item_s1;
	rec_t       rec_s2;
	line_word_t line_q;
	logic       fire_s1, adv_s2, has_res;

	// Forwarding of the newest table writes
	logic          fwd_st_valid_q, fwd_k_valid_q;
	logic [PW-1:0] fwd_st_part_q, fwd_k_part_q;
	part_state_t   fwd_st_q;
	logic [1:0]    fwd_k_slot_q;
	logic [63:0]   fwd_k_q;

	// Table ports
	logic                 st_we;
	logic [PW-1:0]        st_waddr;
	part_state_t          st_wdata;
	logic [STW-1:0]       st_rdata;
	logic                 k_we;
	logic [63:0]          k_rdata [BUF_SLOTS];
	logic [PW-1:0]        p;

	// Stage one working values
	part_state_t          st, nst;
	logic [63:0]          bkeys [BUF_SLOTS];
	logic [1:0]           slot;
	logic [18:0]          next_tgt;
	rec_t                 rec;

	// Stage two arithmetic
	logic [63:0] bi_prod;
	logic [41:0] tot_prod;

	assign clearing = clr_q;
	assign p        = item_s1.part[PW-1:0];

	assign adv_s2  = valid_s2 && (!line_valid_q || !line_stall);
	assign fire_s1 = valid_s1 && (!has_res || !valid_s2 || adv_s2);
	assign q_pop   = !clr_q && q_valid && (!valid_s1 || fire_s1);

	// Sweep the state table to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == PW'(PARTITIONS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign st_we    = clr_q || fire_s1;
	assign st_waddr = clr_q ? clr_idx_q : p;
	assign st_wdata = clr_q ? '0 : nst;

	rpwc_ram #(.WIDTH(STW), .DEPTH(PARTITIONS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (q_pop),
		.raddr (q_item.part[PW-1:0]),
		.rdata (st_rdata)
	);

	// One key RAM per buffer slot
	for (genvar s = 0; s < BUF_SLOTS; s++) begin : g_key_ram
		rpwc_ram #(.WIDTH(64), .DEPTH(PARTITIONS)) u_key_ram (
			.clk   (clk),
			.we    (k_we && (slot == 2'(s))),
			.waddr (p),
			.wdata (item_s1.key),
			.re    (q_pop),
			.raddr (q_item.part[PW-1:0]),
			.rdata (k_rdata[s])
		);
	end

	// Merge forwarded values and apply the word to the partition state
	always_comb begin
		st = (fwd_st_valid_q && fwd_st_part_q == p) ? fwd_st_q : part_state_t'(st_rdata);
		for (int s = 0; s < BUF_SLOTS; s++) begin
			bkeys[s] = (fwd_k_valid_q && fwd_k_part_q == p && fwd_k_slot_q == 2'(s))
				? fwd_k_q : k_rdata[s];
		end
		slot     = st.fill;
		next_tgt = {1'b0, st.target} + 19'(LINE_ENTRIES);
		nst      = st;
		k_we     = 1'b0;
		has_res  = 1'b0;
		rec.part   = item_s1.part;
		rec.filled = st.filled;
		rec.target = st.target;
		rec.count  = '0;
		rec.keys   = '0;
		rec.full   = 1'b0;
		if (item_s1.cmd == CMD_FLUSH) begin
			has_res    = 1'b1;
			rec.count  = 3'(slot);
			for (int s = 0; s < BUF_SLOTS; s++) begin
				if (2'(s) < slot) begin
					rec.keys[s] = bkeys[s];
				end
			end
			nst.target = st.target + 18'(slot);
			nst.fill   = '0;
		end else if (slot != LAST_SLOT) begin
			k_we     = fire_s1;
			nst.fill = slot + 1'b1;
		end else begin
			has_res   = 1'b1;
			rec.count = 3'(LINE_ENTRIES);
			for (int s = 0; s < BUF_SLOTS; s++) begin
				rec.keys[s] = bkeys[s];
			end
			rec.keys[LINE_ENTRIES-1] = item_s1.key;
			rec.full = (next_tgt >= {1'b0, cfg.entries_per_block});
			if (rec.full) begin
				nst.filled = st.filled + 1'b1;
				nst.target = '0;
			end else begin
				nst.target = next_tgt[17:0];
			end
			nst.fill = '0;
		end
	end

	// Record the newest writes for the word right behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_st_valid_q <= 1'b0;
			fwd_k_valid_q  <= 1'b0;
		end else begin
			if (fire_s1) begin
				fwd_st_valid_q <= 1'b1;
			end
			if (k_we) begin
				fwd_k_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			fwd_st_part_q <= p;
			fwd_st_q      <= nst;
		end
		if (k_we) begin
			fwd_k_part_q <= p;
			fwd_k_slot_q <= slot;
			fwd_k_q      <= item_s1.key;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			line_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1 && has_res) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				line_valid_q <= 1'b1;
			end else if (!line_stall) begin
				line_valid_q <= 1'b0;
			end
		end
	end

	// Block index and running total
	always_comb begin
		bi_prod  = 64'(rec_s2.filled) * 64'(PARTITIONS) + 64'(rec_s2.part);
		tot_prod = 42'(rec_s2.filled) * 42'(cfg.entries_per_block)
			+ 42'(rec_s2.target) + 42'(rec_s2.count);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
		end
		if (fire_s1 && has_res) begin
			rec_s2 <= rec;
		end
		if (adv_s2) begin
			line_q.partition       <= rec_s2.part;
			line_q.block_index     <= bi_prod[31:0];
			line_q.offset_in_block <= rec_s2.target[16:0];
			line_q.entry_count     <= rec_s2.count;
			line_q.key_first       <= rec_s2.keys[0];
			line_q.key_second      <= rec_s2.keys[1];
			line_q.key_third       <= rec_s2.keys[2];
			line_q.key_fourth      <= rec_s2.keys[3];
			line_q.block_full      <= rec_s2.full;
			line_q.partition_total <= tot_prod[39:0];
		end
	end

	assign line_valid = line_valid_q;
	assign line       = line_q;

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !q_pop && !valid_s1) else $error("word entered during clear");
	a_full_is_line: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rec_s2.full |-> rec_s2.count == 3'(LINE_ENTRIES))
		else $error("block closed by a flush");
	a_line_clears_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && has_res |-> nst.fill == 2'd0) else $error("fill kept after write");

endmodule

/* src/radix_partition_write_combiner_top.sv */
// Top level of the radix partition write combiner.
// Depends on rpwc_pkg, rpwc_front, rpwc_queue, rpwc_back and rpwc_ram.
//
// Usage:
//   item channel (item_valid/item_stall/item): a key to partition (cmd 0) or a
//   flush of one partition (cmd 1). A word is taken when valid is high and stall low.
//   line channel (line_valid/line_stall/line): line writes of four keys and flush
//   results, one word per line-completing key or per flush.
//   cfg port: cfg_we writes cfg_index (0 partition bits, 1 entries per block) with
//   cfg_data; write only while no word is in flight.
// Throughput: one word per cycle while line_stall is low, sustained, including
// back-to-back words to the same partition; the partition tables forward the
// newest write to the next word. Path: two front stages, queue, table read,
// combine, then index/total multiply into the output register.
// Reset: configuration returns to 8 partition bits and 256 entries per block, and a
// clear sweep zeroes every entry of the partition table with item_stall high.
// Stall: line_stall holds the output word; the pipeline and the four-entry queue
// fill up before item_stall rises.
module radix_partition_write_combiner_top import rpwc_pkg::*; #(
	parameter int PARTITIONS = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  item_word_t             item,
	output logic                   line_valid,
	input  logic                   line_stall,
	output line_word_t             line,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   clearing, push, q_full, q_valid, q_pop;
	qitem_t push_item, q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.partition_bits    <= 4'd8;
			cfg_q.entries_per_block <= 18'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PARTITION_BITS:    cfg_q.partition_bits    <= cfg_data[3:0];
				CFG_ENTRIES_PER_BLOCK: cfg_q.entries_per_block <= cfg_data;
				default: ;
			endcase
		end
	end

	rpwc_front #(.PARTITIONS(PARTITIONS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.hold       (clearing),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	rpwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head),
		.pop       (q_pop)
	);

	rpwc_back #(.PARTITIONS(PARTITIONS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line       (line)
	);

endmodule
